@@ src/bb3_pkg.sv @@
// bb3_pkg: shared constants, types and the reciprocal table of the 3x3 box blur
// no dependencies, used by bb3_window, bb3_avg, the top level and the checker
package bb3_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 4096;

  localparam int CH_BITS          = 8;
  localparam int PIX_BITS         = 3 * CH_BITS;
  localparam int FW_BITS          = 11;
  localparam int FH_BITS          = 13;
  localparam int CFG_BITS         = 13;
  localparam int SUM_BITS         = 12;   // nine 8-bit terms
  localparam int CNT_BITS         = 4;    // 1 to 9 neighbors
  localparam int NUM_BITS         = 13;   // 2*sum + count
  localparam int RECIP_SHIFT      = 18;
  localparam int RECIP_BITS       = 18;

  localparam int RST_FRAME_WIDTH  = 1024;
  localparam int RST_FRAME_HEIGHT = 768;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_BITS-1:0] pix_t;

  typedef struct packed {
    logic       shift;
    logic       clear;
    logic [2:0] row_ok;   // bit 0 top row
    logic [2:0] col_ok;   // bit 0 left column
  } win_ctl_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum_b;
    logic [SUM_BITS-1:0] sum_g;
    logic [SUM_BITS-1:0] sum_r;
    logic [CNT_BITS-1:0] count;
  } win_sum_t;

  // ceil(2^18 / (2*count)), exact quotient for numerators below 2^13
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] count);
    logic [RECIP_BITS-1:0] m;
    case (count)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd5:    m = 18'd26215;
      4'd6:    m = 18'd21846;
      4'd7:    m = 18'd18725;
      4'd8:    m = 18'd16384;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ src/bb3_line_mem.sv @@
// bb3_line_mem: line store with one read and one write port, holding the two rows above the input row
// synchronous read, data registered in the cycle after re_i; no package dependency
module bb3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bb3_window.sv @@
// bb3_window: left and center window columns plus masked 3x3 channel sums
// depends on bb3_pkg for pixel, control and sum types
module bb3_window (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bb3_pkg::win_ctl_t                      ctl_i,
  input  logic [2:0][bb3_pkg::PIX_BITS-1:0]      col_i,
  output bb3_pkg::win_sum_t                      sum_o
);

  logic [2:0][bb3_pkg::PIX_BITS-1:0] left_q, left_d;
  logic [2:0][bb3_pkg::PIX_BITS-1:0] mid_q, mid_d;

  always_comb begin
    left_d = left_q;
    mid_d  = mid_q;
    if (ctl_i.clear) begin
      left_d = '0;
      mid_d  = '0;
    end else if (ctl_i.shift) begin
      left_d = mid_q;
      mid_d  = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      mid_q  <= '0;
    end else begin
      left_q <= left_d;
      mid_q  <= mid_d;
    end
  end

  // nine terms, each used only where its row and column lie in the frame
  always_comb begin
    logic [2:0][bb3_pkg::PIX_BITS-1:0] cols [3];
    logic                              use_it;
    sum_o = '0;
    cols[0] = left_q;
    cols[1] = mid_q;
    cols[2] = col_i;
    for (int ci = 0; ci < 3; ci++) begin
      for (int ri = 0; ri < 3; ri++) begin
        use_it = ctl_i.col_ok[ci] & ctl_i.row_ok[ri];
        if (use_it) begin
          sum_o.sum_r = sum_o.sum_r + bb3_pkg::SUM_BITS'(cols[ci][ri][7:0]);
          sum_o.sum_g = sum_o.sum_g + bb3_pkg::SUM_BITS'(cols[ci][ri][15:8]);
          sum_o.sum_b = sum_o.sum_b + bb3_pkg::SUM_BITS'(cols[ci][ri][23:16]);
          sum_o.count = sum_o.count + bb3_pkg::CNT_BITS'(1);
        end
      end
    end
  end

endmodule

@@ src/bb3_avg.sv @@
// bb3_avg: rounded average by reciprocal multiply and the output beat register
// depends on bb3_pkg for the sum type and the reciprocal table
module bb3_avg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  bb3_pkg::win_sum_t             sum_i,
  input  logic                          last_i,
  input  logic                          m_axis_tready,
  output logic [bb3_pkg::PIX_BITS-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid
);

  localparam int PW = bb3_pkg::NUM_BITS + bb3_pkg::RECIP_BITS;

  logic [bb3_pkg::RECIP_BITS-1:0] m;
  logic [2:0][bb3_pkg::SUM_BITS-1:0] sums;
  logic [bb3_pkg::PIX_BITS-1:0] data_d, data_q;
  logic last_q, valid_q;

  assign m    = bb3_pkg::recip(sum_i.count);
  assign sums = {sum_i.sum_b, sum_i.sum_g, sum_i.sum_r};

  // (2*sum + count) / (2*count), half-up rounding
  always_comb begin
    logic [bb3_pkg::NUM_BITS-1:0] num;
    logic [PW-1:0]                prod;
    data_d = '0;
    for (int ch = 0; ch < 3; ch++) begin
      num  = {sums[ch], 1'b0} + bb3_pkg::NUM_BITS'(sum_i.count);
      prod = PW'(num) * PW'(m);
      data_d[ch*bb3_pkg::CH_BITS +: bb3_pkg::CH_BITS] =
        prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
      last_q <= last_i;
    end
  end

  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tvalid = valid_q;

endmodule

@@ src/box_blur_3x3_rgb_top.sv @@
// box_blur_3x3_rgb_top: streaming 3x3 box blur over an RGB frame in raster order
// depends on bb3_pkg, bb3_line_mem, bb3_window and bb3_avg
//
// Each accepted beat carries one pixel; each output beat is the per-channel
// 3x3 average of an earlier pixel, with out-of-frame neighbors left out and
// half-up rounding. The result for pixel n comes with input beat
// n + frame_width + 1, so after the last pixel the host sends frame_width + 1
// drain beats (tuser = 1) to flush the last row; the frame then restarts at
// row 0, column 0. Each pixel passes the accept cycle that addresses the line
// memory, the cycle in which the read data forms the window sums and the
// memory entry is written back, and the cycle of the reciprocal multiply that
// loads the output register. A stalled output stretches that last step until
// the register frees up; the next pixel is taken while a finished result
// waits. Both row stores share one MAX_WIDTH-entry memory with one read and
// one write port, each entry holding the row two above and the row just above
// the input row. Entries need no clearing after reset: rows outside the frame
// are masked out of the sums. The user is to write configuration only while
// the block is idle; the block does not enforce this. Every write restarts
// the frame. Only the low FW_BITS data bits set the width; widths above
// MAX_WIDTH and heights above MAX_HEIGHT are clamped, zero is taken as one.
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bb3_pkg::PIX_BITS-1:0]  s_axis_tdata,   // pix_red, pix_green, pix_blue
  input  logic                          s_axis_tuser,   // drain
  // blurred output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bb3_pkg::PIX_BITS-1:0]  m_axis_tdata,   // out_red, out_green, out_blue
  output logic                          m_axis_tlast,   // frame_end
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bb3_pkg::CFG_BITS-1:0]  cfg_data_i
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int RST_W = (bb3_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                         MAX_WIDTH : bb3_pkg::RST_FRAME_WIDTH;
  localparam int RST_H = (bb3_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                         MAX_HEIGHT : bb3_pkg::RST_FRAME_HEIGHT;
  localparam int PW    = bb3_pkg::PIX_BITS;

  localparam int FW_BITS_L = bb3_pkg::FW_BITS;
  localparam int FH_BITS_L = bb3_pkg::FH_BITS;

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [CW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] pix_q;

  logic accept, in_read, restart, produce, frame_end, avg_load;
  logic top_ok, bot_ok, left_ok, right_ok;
  logic [31:0] c32, r32, w32, h32;
  logic [AW:0] col_inc;
  logic [FW_BITS_L-1:0] cfg_w;
  logic [FH_BITS_L-1:0] cfg_h;
  logic [2*PW-1:0] mem_rdata;

  bb3_pkg::win_ctl_t win_ctl;
  bb3_pkg::win_sum_t win_sum, sum_q;
  logic              produce_q, last_q;

  assign c32 = 32'(col_q);
  assign r32 = 32'(row_q);
  assign w32 = 32'(width_q);
  assign h32 = 32'(height_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_read       = (state_q == ST_READ);

  // a stream position past the frame falls back to the frame start
  assign restart = (c32 >= w32) || (r32 > h32 + 32'd1);

  // --------------------------------------------------------------------------
  // configuration registers, clamped on write
  // --------------------------------------------------------------------------
  assign cfg_w = cfg_data_i[bb3_pkg::FW_BITS-1:0];
  assign cfg_h = cfg_data_i[bb3_pkg::FH_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(RST_W);
      height_q <= HW'(RST_H);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bb3_pkg::REG_FRAME_WIDTH: begin
          if (cfg_w == '0) begin
            width_q <= CW'(1);
          end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            width_q <= CW'(MAX_WIDTH);
          end else begin
            width_q <= CW'(cfg_w);
          end
        end
        bb3_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_h == '0) begin
            height_q <= HW'(1);
          end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
            height_q <= HW'(MAX_HEIGHT);
          end else begin
            height_q <= HW'(cfg_h);
          end
        end
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // neighbor masks for the output pixel behind the input position
  // --------------------------------------------------------------------------
  always_comb begin
    if (col_q != '0) begin
      // output at row r-1, column c-1
      produce   = (r32 >= 32'd1) && (r32 <= h32);
      top_ok    = (r32 >= 32'd2);
      bot_ok    = (r32 < h32);
      left_ok   = (c32 >= 32'd2);
      right_ok  = 1'b1;
      frame_end = 1'b0;
    end else begin
      // output at row r-2, last column of the row
      produce   = (r32 >= 32'd2) && (r32 <= h32 + 32'd1);
      top_ok    = (r32 >= 32'd3);
      bot_ok    = (r32 <= h32);
      left_ok   = (w32 >= 32'd2);
      right_ok  = 1'b0;
      frame_end = (r32 == h32 + 32'd1);
    end
  end

  assign win_ctl.shift  = in_read;
  assign win_ctl.clear  = cfg_we_i | (accept & restart) | (in_read & produce & frame_end);
  assign win_ctl.row_ok = {bot_ok, 1'b1, top_ok};
  assign win_ctl.col_ok = {right_ok, 1'b1, left_ok};

  // --------------------------------------------------------------------------
  // line memory: upper half older row, lower half newer row
  // --------------------------------------------------------------------------
  bb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (2 * PW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (restart ? AW'(0) : col_q),
    .we_i    (in_read),
    .waddr_i (col_q),
    .wdata_i ({mem_rdata[PW-1:0], pix_q}),
    .rdata_o (mem_rdata)
  );

  bb3_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (win_ctl),
    .col_i  ({pix_q, mem_rdata[PW-1:0], mem_rdata[2*PW-1:PW]}),
    .sum_o  (win_sum)
  );

  // --------------------------------------------------------------------------
  // stream position and sequencer
  // --------------------------------------------------------------------------
  assign col_inc = {1'b0, col_q} + (AW + 1)'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept && restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_read) begin
      if (produce && frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (32'(col_inc) >= w32) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_inc[AW-1:0];
      end
    end
  end

  assign avg_load = (state_q == ST_DIV) && produce_q && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!produce_q || avg_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      produce_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (in_read) begin
        produce_q <= produce;
      end
    end
  end

  // pixel and window sums
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= s_axis_tuser ? '0 : s_axis_tdata;
    end
    if (in_read) begin
      sum_q  <= win_sum;
      last_q <= frame_end;
    end
  end

  bb3_avg u_avg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (avg_load),
    .sum_i         (sum_q),
    .last_i        (last_q),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid)
  );

endmodule

@@ src/bb3_checker.sv @@
// bb3_checker: port-level assertions for the box blur top level, and its bind
// depends on bb3_pkg for port widths; binds to box_blur_3x3_rgb_top
module bb3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bb3_pkg::PIX_BITS-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);

  logic in_beat;
  assign in_beat = s_axis_tvalid & s_axis_tready;

  // one pixel in flight: the input stays closed for the read and average cycles
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened while a pixel was in flight");

  // a result never appears in the cycle right after its pixel was taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output beat appeared too early");

  // the output register is loaded only while the input is closed
  a_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output loaded while the input side was idle");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (.*);
